>>> sv/p2o_pkg.sv
// ----------------------------------------------------------------------------
// p2o_pkg: shared types and constants of the path-to-outline converter
// Point, transform and sequencer hand-over types; request and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package p2o_pkg;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    coord_t m_xx;
    coord_t m_xy;
    coord_t m_tx;
    coord_t m_yx;
    coord_t m_yy;
    coord_t m_ty;
  } xform_t;

  // transformed request handed from the lanes to the sequencer
  typedef struct packed {
    logic [2:0] req;
    pt_t        p0;
    pt_t        p1;
    pt_t        p2;
    pt_t        pp;
  } item_t;

  localparam logic [2:0] REQ_CLOSE = 3'd0;
  localparam logic [2:0] REQ_MOVE  = 3'd1;
  localparam logic [2:0] REQ_LINE  = 3'd2;
  localparam logic [2:0] REQ_CUBIC = 3'd3;
  localparam logic [2:0] REQ_END   = 3'd4;

  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [2:0] REG_M_XX          = 3'd0;
  localparam logic [2:0] REG_M_XY          = 3'd1;
  localparam logic [2:0] REG_M_TX          = 3'd2;
  localparam logic [2:0] REG_M_YX          = 3'd3;
  localparam logic [2:0] REG_M_YY          = 3'd4;
  localparam logic [2:0] REG_M_TY          = 3'd5;
  localparam logic [2:0] REG_HAS_COMPOSITE = 3'd6;

  localparam coord_t COORD_MAX = 32'sh7fffffff;
  localparam coord_t COORD_MIN = 32'sh80000001;

  localparam logic [2:0] PC_SAT      = 3'd6;
  localparam logic [2:0] RECT_POINTS = 3'd5;
  localparam logic [2:0] PC_THIRD    = 3'd2;

endpackage

`default_nettype wire

>>> sv/p2o_if.sv
// ----------------------------------------------------------------------------
// p2o_if: request and result channels of the path-to-outline converter
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface p2o_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] x0;
  logic signed [31:0] y0;
  logic signed [31:0] x1;
  logic signed [31:0] y1;
  logic signed [31:0] x2;
  logic signed [31:0] y2;

  modport source (output valid, req_type, x0, y0, x1, y1, x2, y2, input ready);
  modport sink (input valid, req_type, x0, y0, x1, y1, x2, y2, output ready);
endinterface

interface p2o_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic               is_control;
  logic               contour_closed;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic               fast_track;
  logic               empty_path;
  logic               last;

  modport source (output valid, kind, px, py, is_control, contour_closed, box_min_x,
                  box_min_y, box_max_x, box_max_y, fast_track, empty_path, last,
                  input ready);
  modport sink (input valid, kind, px, py, is_control, contour_closed, box_min_x,
                box_min_y, box_max_x, box_max_y, fast_track, empty_path, last,
                output ready);
endinterface

`default_nettype wire

>>> sv/p2o_lane.sv
// ----------------------------------------------------------------------------
// p2o_lane: one affine transform lane
// Three stages: products, sum, truncate toward zero and saturate to 26.6.
// ----------------------------------------------------------------------------
`default_nettype none

module p2o_lane
  import p2o_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  xform_t m,
  input  pt_t    pin,
  output pt_t    pout
);

  logic signed [63:0] pxx, pxy, pyx, pyy;
  coord_t             tx, ty;
  logic signed [65:0] sx, sy;

  function automatic coord_t to_q6(input logic signed [65:0] s);
    logic signed [47:0] h;
    logic               adj;
    adj = s[65] && (s[17:0] != 18'd0);
    h   = $signed(s[65:18]) + $signed({47'd0, adj});
    if (h > 48'sd2147483647) begin
      return COORD_MAX;
    end else if (h < -48'sd2147483647) begin
      return COORD_MIN;
    end else begin
      return coord_t'(h[31:0]);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= $signed(m.m_xx) * $signed(pin.x);
      pxy <= $signed(m.m_xy) * $signed(pin.y);
      pyx <= $signed(m.m_yx) * $signed(pin.x);
      pyy <= $signed(m.m_yy) * $signed(pin.y);
      tx  <= m.m_tx;
      ty  <= m.m_ty;
      sx  <= $signed({{2{pxx[63]}}, pxx}) + $signed({{2{pxy[63]}}, pxy})
           + $signed({{18{tx[31]}}, tx, 16'd0});
      sy  <= $signed({{2{pyx[63]}}, pyx}) + $signed({{2{pyy[63]}}, pyy})
           + $signed({{18{ty[31]}}, ty, 16'd0});
      pout.x <= to_q6(sx);
      pout.y <= to_q6(sy);
    end
  end

endmodule

`default_nettype wire

>>> sv/p2o_merge.sv
// ----------------------------------------------------------------------------
// p2o_merge: result sequencer and path state
// Turns one transformed request into its results, one per cycle unless res
// stalls; keeps contour, box and rectangle state; drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module p2o_merge
  import p2o_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  has_composite,
  input  logic  load_valid,
  output logic  load_ready,
  input  item_t item,
  p2o_res_if.source res
);

  typedef enum logic [2:0] {ST_FIRST, ST_REPEAT, ST_P0, ST_P1, ST_P2} step_t;

  step_t      step, step_next;
  logic       mvalid;
  item_t      cur;
  logic       closed;
  logic [2:0] pc;
  logic       has_pts;
  pt_t        start;
  pt_t        last_pt;
  pt_t        first_pts [4];
  logic       third;
  coord_t     bmin_x, bmin_y, bmax_x, bmax_y;
  coord_t     bmin_x_next, bmin_y_next, bmax_x_next, bmax_y_next;

  logic       ovalid, olast, octrl, oclosed, ofast, oempty;
  logic [1:0] okind;
  coord_t     opx, opy, obminx, obminy, obmaxx, obmaxy;

  logic emit, done, is_pt, is_end, end_cl, is_sum, ctrl;
  logic cap_prev, cap_pt, set_closed, clr_closed, cubic;
  logic out_en, fire, fast;
  logic a2, b2, a4, b4;
  pt_t  pt;

  always_comb begin
    emit       = 1'b0;
    done       = 1'b0;
    step_next  = step;
    is_pt      = 1'b0;
    is_end     = 1'b0;
    end_cl     = 1'b0;
    is_sum     = 1'b0;
    pt         = cur.p0;
    ctrl       = 1'b0;
    cap_prev   = 1'b0;
    cap_pt     = 1'b0;
    set_closed = 1'b0;
    clr_closed = 1'b0;
    cubic      = (cur.req == REQ_CUBIC);
    case (cur.req)
      REQ_CLOSE: begin
        if (step == ST_FIRST) begin
          if (!closed && has_pts) begin
            emit      = 1'b1;
            is_pt     = 1'b1;
            pt        = start;
            step_next = ST_P0;
          end else begin
            done = 1'b1;
          end
        end else begin
          emit       = 1'b1;
          is_end     = 1'b1;
          end_cl     = 1'b1;
          set_closed = 1'b1;
          done       = 1'b1;
        end
      end
      REQ_MOVE: begin
        emit = 1'b1;
        if (step == ST_FIRST && !closed && pc != 3'd0) begin
          is_end    = 1'b1;
          step_next = ST_P0;
        end else begin
          is_pt      = 1'b1;
          cap_pt     = 1'b1;
          clr_closed = 1'b1;
          done       = 1'b1;
        end
      end
      REQ_LINE, REQ_CUBIC: begin
        emit = 1'b1;
        case (step)
          ST_FIRST: begin
            cap_prev = cubic && pc != 3'd0;
            if (closed) begin
              is_end    = 1'b1;
              step_next = ST_REPEAT;
            end else begin
              is_pt     = 1'b1;
              ctrl      = cubic;
              cap_pt    = 1'b1;
              step_next = ST_P1;
              done      = !cubic;
            end
          end
          ST_REPEAT: begin
            is_pt      = 1'b1;
            pt         = last_pt;
            clr_closed = 1'b1;
            step_next  = ST_P0;
          end
          ST_P0: begin
            is_pt     = 1'b1;
            ctrl      = cubic;
            cap_pt    = 1'b1;
            step_next = ST_P1;
            done      = !cubic;
          end
          ST_P1: begin
            is_pt     = 1'b1;
            pt        = cur.p1;
            ctrl      = 1'b1;
            cap_pt    = 1'b1;
            step_next = ST_P2;
          end
          ST_P2: begin
            is_pt  = 1'b1;
            pt     = cur.p2;
            cap_pt = 1'b1;
            done   = 1'b1;
          end
          default: begin
            emit = 1'b0;
            done = 1'b1;
          end
        endcase
      end
      REQ_END: begin
        emit = 1'b1;
        if (step == ST_FIRST && !closed && pc != 3'd0) begin
          is_end    = 1'b1;
          step_next = ST_P0;
        end else begin
          is_sum = 1'b1;
          done   = 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    bmin_x_next = bmin_x;
    bmin_y_next = bmin_y;
    bmax_x_next = bmax_x;
    bmax_y_next = bmax_y;
    if (cap_prev) begin
      if ($signed(cur.pp.x) < bmin_x_next) bmin_x_next = cur.pp.x;
      if ($signed(cur.pp.y) < bmin_y_next) bmin_y_next = cur.pp.y;
      if ($signed(cur.pp.x) > bmax_x_next) bmax_x_next = cur.pp.x;
      if ($signed(cur.pp.y) > bmax_y_next) bmax_y_next = cur.pp.y;
    end
    if (cap_pt) begin
      if ($signed(pt.x) < bmin_x_next) bmin_x_next = pt.x;
      if ($signed(pt.y) < bmin_y_next) bmin_y_next = pt.y;
      if ($signed(pt.x) > bmax_x_next) bmax_x_next = pt.x;
      if ($signed(pt.y) > bmax_y_next) bmax_y_next = pt.y;
    end
    if (is_sum) begin
      bmin_x_next = COORD_MAX;
      bmin_y_next = COORD_MAX;
      bmax_x_next = COORD_MIN;
      bmax_y_next = COORD_MIN;
    end
  end

  assign a2   = (first_pts[1].x == first_pts[0].x) && (first_pts[1].y == first_pts[2].y);
  assign b2   = (first_pts[1].x == first_pts[2].x) && (first_pts[1].y == first_pts[0].y);
  assign a4   = (first_pts[3].x == first_pts[0].x) && (first_pts[3].y == first_pts[2].y);
  assign b4   = (first_pts[3].x == first_pts[2].x) && (first_pts[3].y == first_pts[0].y);
  assign fast = !has_composite && pc == RECT_POINTS && !third && ((a2 && b4) || (b2 && a4));

  assign out_en     = !ovalid || res.ready;
  assign fire       = mvalid && (!emit || out_en);
  assign load_ready = !mvalid || (fire && done);

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid  <= 1'b0;
      step    <= ST_FIRST;
      closed  <= 1'b0;
      pc      <= 3'd0;
      has_pts <= 1'b0;
      start   <= '0;
      last_pt <= '0;
      third   <= 1'b0;
      bmin_x  <= COORD_MAX;
      bmin_y  <= COORD_MAX;
      bmax_x  <= COORD_MIN;
      bmax_y  <= COORD_MIN;
      ovalid  <= 1'b0;
    end else begin
      if (out_en) begin
        ovalid <= fire && emit;
        okind  <= is_sum ? KIND_SUMMARY : (is_end ? KIND_END : KIND_POINT);
        opx    <= is_pt ? pt.x : '0;
        opy    <= is_pt ? pt.y : '0;
        octrl  <= is_pt && ctrl;
        oclosed <= is_end && end_cl;
        obminx <= is_sum ? bmin_x : '0;
        obminy <= is_sum ? bmin_y : '0;
        obmaxx <= is_sum ? bmax_x : '0;
        obmaxy <= is_sum ? bmax_y : '0;
        ofast  <= is_sum && fast;
        oempty <= is_sum && pc == 3'd0;
        olast  <= done;
      end
      if (fire) begin
        step   <= done ? ST_FIRST : step_next;
        bmin_x <= bmin_x_next;
        bmin_y <= bmin_y_next;
        bmax_x <= bmax_x_next;
        bmax_y <= bmax_y_next;
        if (set_closed) closed <= 1'b1;
        if (clr_closed) closed <= 1'b0;
        if (is_pt) begin
          if (!has_pts) begin
            start   <= pt;
            has_pts <= 1'b1;
          end
          if (!pc[2]) first_pts[pc[1:0]] <= pt;
          if (pc == PC_THIRD) third <= ctrl;
          if (pc != PC_SAT) pc <= pc + 3'd1;
          last_pt <= pt;
        end
        if (is_end) has_pts <= 1'b0;
        if (is_sum) begin
          closed  <= 1'b0;
          pc      <= 3'd0;
          has_pts <= 1'b0;
          start   <= '0;
          last_pt <= '0;
          third   <= 1'b0;
        end
      end
      if (load_valid && load_ready) begin
        mvalid <= 1'b1;
        cur    <= item;
      end else if (fire && done) begin
        mvalid <= 1'b0;
      end
    end
  end

  assign res.valid          = ovalid;
  assign res.kind           = okind;
  assign res.px             = opx;
  assign res.py             = opy;
  assign res.is_control     = octrl;
  assign res.contour_closed = oclosed;
  assign res.box_min_x      = obminx;
  assign res.box_min_y      = obminy;
  assign res.box_max_x      = obmaxx;
  assign res.box_max_y      = obmaxy;
  assign res.fast_track     = ofast;
  assign res.empty_path     = oempty;
  assign res.last           = olast;

endmodule

`default_nettype wire

>>> sv/path_to_outline_converter.sv
// ----------------------------------------------------------------------------
// path_to_outline_converter: vector path commands to 26.6 outline points
//
//   channel  direction  handshake       payload
//   cmd      in         valid / ready   req_type, x0..y2 (Q24.8)
//   res      out        valid / ready   kind, px, py, flags, box, last
//   apb      in         psel / penable  m_xx..m_ty, has_composite
//
// Four transform lanes (three request points and the previous path point)
// run in a three-stage multiply, sum, saturate pipeline; a request enters
// every cycle while the sequencer has room.
// The sequencer gives a request's results one after another, up to five; a
// request that gives nothing still passes through it. The first result goes
// through the lane stages, the request register and the result register.
// Reset is synchronous; no clearing pass. A stalled result holds the
// sequencer, which in turn holds the lane pipeline and cmd.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module path_to_outline_converter
  import p2o_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  p2o_cmd_if.sink     cmd,
  p2o_res_if.source   res
);

  xform_t     m;
  logic       has_composite;
  pt_t        prev_in;
  logic [2:0] pv;
  logic [2:0] preq [3];
  logic       pipe_en, acc, load_ready;
  pt_t        in0, in1, in2;
  pt_t        out0, out1, out2, outp;
  item_t      item;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m.m_xx        <= 32'sd65536;
      m.m_xy        <= '0;
      m.m_tx        <= '0;
      m.m_yx        <= '0;
      m.m_yy        <= 32'sd65536;
      m.m_ty        <= '0;
      has_composite <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_M_XX:          m.m_xx <= pwdata;
        REG_M_XY:          m.m_xy <= pwdata;
        REG_M_TX:          m.m_tx <= pwdata;
        REG_M_YX:          m.m_yx <= pwdata;
        REG_M_YY:          m.m_yy <= pwdata;
        REG_M_TY:          m.m_ty <= pwdata;
        REG_HAS_COMPOSITE: has_composite <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_M_XX:          prdata = m.m_xx;
      REG_M_XY:          prdata = m.m_xy;
      REG_M_TX:          prdata = m.m_tx;
      REG_M_YX:          prdata = m.m_yx;
      REG_M_YY:          prdata = m.m_yy;
      REG_M_TY:          prdata = m.m_ty;
      REG_HAS_COMPOSITE: prdata = {31'd0, has_composite};
      default:           prdata = '0;
    endcase
  end

  assign pipe_en   = !pv[2] || load_ready;
  assign cmd.ready = pipe_en;
  assign acc       = cmd.valid && pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv      <= '0;
      prev_in <= '0;
    end else begin
      if (pipe_en) begin
        pv      <= {pv[1:0], acc};
        preq[0] <= cmd.req_type;
        preq[1] <= preq[0];
        preq[2] <= preq[1];
      end
      if (acc) begin
        case (cmd.req_type)
          REQ_MOVE, REQ_LINE: begin
            prev_in.x <= cmd.x0;
            prev_in.y <= cmd.y0;
          end
          REQ_CUBIC: begin
            prev_in.x <= cmd.x2;
            prev_in.y <= cmd.y2;
          end
          REQ_END: prev_in <= '0;
          default: begin
          end
        endcase
      end
    end
  end

  assign in0.x = cmd.x0;
  assign in0.y = cmd.y0;
  assign in1.x = cmd.x1;
  assign in1.y = cmd.y1;
  assign in2.x = cmd.x2;
  assign in2.y = cmd.y2;

  p2o_lane u_lane0 (.clk(clk), .en(pipe_en), .m(m), .pin(in0),     .pout(out0));
  p2o_lane u_lane1 (.clk(clk), .en(pipe_en), .m(m), .pin(in1),     .pout(out1));
  p2o_lane u_lane2 (.clk(clk), .en(pipe_en), .m(m), .pin(in2),     .pout(out2));
  p2o_lane u_lanep (.clk(clk), .en(pipe_en), .m(m), .pin(prev_in), .pout(outp));

  assign item.req = preq[2];
  assign item.p0  = out0;
  assign item.p1  = out1;
  assign item.p2  = out2;
  assign item.pp  = outp;

  p2o_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .has_composite(has_composite),
    .load_valid   (pv[2]),
    .load_ready   (load_ready),
    .item         (item),
    .res          (res)
  );

endmodule

`default_nettype wire
